/* design/xtm_pkg.sv */
`default_nettype none

package xtm_pkg;

  localparam int TABLE_SIZE    = 272;
  localparam int POSITION_BITS = 40;

  localparam int ADDR_W  = $clog2(TABLE_SIZE);
  localparam int RED_W   = ADDR_W + 4;
  localparam int IDX_W   = 9;
  localparam int BYTE_W  = 8;
  localparam int SEL_W   = 2;

  // One stage per byte of position, plus the level where the position has run out.
  localparam int NUM_LEVELS = (POSITION_BITS + 7) / 8 + 1;
  localparam int WIN_W      = 8 * NUM_LEVELS;

  // Edges from the transfer of a fetch to the transfer of its mask byte.
  localparam int LATENCY = NUM_LEVELS + 2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  localparam logic [SEL_W-1:0] SEL_FIRST  = 2'd0;
  localparam logic [SEL_W-1:0] SEL_SECOND = 2'd1;
  localparam logic [SEL_W-1:0] SEL_BASE   = 2'd2;

  typedef struct packed {
    logic                  valid;
    logic                  wr;
    logic [SEL_W-1:0]      sel;
    logic [IDX_W-1:0]      idx;
    logic [BYTE_W-1:0]     wbyte;
    logic [WIN_W-1:0]      win;
    logic [NUM_LEVELS-1:0] act;
    logic [NUM_LEVELS-1:0] term;
    logic                  last;
    logic [BYTE_W-1:0]     acc;
    logic [ADDR_W-1:0]     rem;
  } item_t;

  typedef struct packed {
    logic              act;
    logic              term;
    logic [BYTE_W-1:0] first_q;
    logic [BYTE_W-1:0] second_q;
    logic [BYTE_W-1:0] base_a;
    logic [BYTE_W-1:0] base_b;
  } rdata_t;

  // Fold one more nibble into a running remainder: (16*rem + nib) mod TABLE_SIZE.
  function automatic logic [ADDR_W-1:0] rem_step(logic [ADDR_W-1:0] rem, logic [3:0] nib);
    logic [RED_W-1:0] x;
    x = {rem, nib};
    for (int i = 3; i >= 0; i--) begin
      if (x >= (RED_W'(TABLE_SIZE) << i)) begin
        x = x - (RED_W'(TABLE_SIZE) << i);
      end
    end
    return x[ADDR_W-1:0];
  endfunction

  // Contribution of one level to the mask byte.
  function automatic logic [BYTE_W-1:0] level_mix(rdata_t rd);
    logic [BYTE_W-1:0] m;
    m = '0;
    if (rd.act) begin
      m = rd.first_q ^ rd.second_q ^ rd.base_a ^ rd.base_b;
    end else if (rd.term) begin
      m = rd.base_a;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

/* design/xtm_level.sv */
`default_nettype none

module xtm_level (
  input  wire logic           clk,
  input  wire logic           rst,
  input  var  xtm_pkg::item_t  item_in,
  input  var  xtm_pkg::rdata_t rd_in,
  output xtm_pkg::item_t       item_out,
  output xtm_pkg::rdata_t      rd_out
);

  logic [xtm_pkg::BYTE_W-1:0] first_mem  [xtm_pkg::TABLE_SIZE];
  logic [xtm_pkg::BYTE_W-1:0] second_mem [xtm_pkg::TABLE_SIZE];
  logic [xtm_pkg::BYTE_W-1:0] base_mem   [xtm_pkg::TABLE_SIZE];

  logic [xtm_pkg::BYTE_W-1:0] first_rd;
  logic [xtm_pkg::BYTE_W-1:0] second_rd;
  logic [xtm_pkg::BYTE_W-1:0] base_lo_rd;
  logic [xtm_pkg::BYTE_W-1:0] base_hi_rd;
  logic                       act_q;
  logic                       term_q;

  logic [7:0]                 hi_byte;
  logic [xtm_pkg::ADDR_W-1:0] r_mid;
  logic [xtm_pkg::ADDR_W-1:0] r_low;
  logic [xtm_pkg::ADDR_W-1:0] wr_addr;
  logic                       fetch;
  logic                       wr_ok;
  xtm_pkg::item_t             item_next;

  // Top byte of the window is this level's byte of the position.
  assign hi_byte = item_in.win[xtm_pkg::WIN_W-1 -: 8];
  assign r_mid   = xtm_pkg::rem_step(item_in.rem, hi_byte[7:4]);
  assign r_low   = xtm_pkg::rem_step(r_mid, hi_byte[3:0]);

  assign fetch   = item_in.valid & ~item_in.wr;
  assign wr_ok   = item_in.valid & item_in.wr & (32'(item_in.idx) < xtm_pkg::TABLE_SIZE);
  assign wr_addr = xtm_pkg::ADDR_W'(item_in.idx);

  always_comb begin
    item_next      = item_in;
    item_next.win  = item_in.win << 8;
    item_next.act  = item_in.act << 1;
    item_next.term = item_in.term << 1;
    item_next.rem  = r_low;
    item_next.acc  = item_in.acc ^ xtm_pkg::level_mix(rd_in);
  end

  // Replica tables: writes land here when the write reaches this level.
  always_ff @(posedge clk) begin
    if (wr_ok && item_in.sel == xtm_pkg::SEL_FIRST) begin
      first_mem[wr_addr] <= item_in.wbyte;
    end
    if (wr_ok && item_in.sel == xtm_pkg::SEL_SECOND) begin
      second_mem[wr_addr] <= item_in.wbyte;
    end
    if (wr_ok && item_in.sel == xtm_pkg::SEL_BASE) begin
      base_mem[wr_addr] <= item_in.wbyte;
    end
    first_rd   <= first_mem[r_mid];
    second_rd  <= second_mem[item_in.rem];
    base_lo_rd <= base_mem[r_low];
    base_hi_rd <= base_mem[item_in.rem];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_out.valid <= 1'b0;
      act_q          <= 1'b0;
      term_q         <= 1'b0;
    end else begin
      item_out <= item_next;
      act_q    <= fetch & item_in.act[xtm_pkg::NUM_LEVELS-1];
      term_q   <= fetch & item_in.term[xtm_pkg::NUM_LEVELS-1];
    end
  end

  always_comb begin
    rd_out.act      = act_q;
    rd_out.term     = term_q;
    rd_out.first_q  = first_rd;
    rd_out.second_q = second_rd;
    rd_out.base_a   = base_lo_rd;
    rd_out.base_b   = base_hi_rd;
  end

endmodule

`default_nettype wire

/* design/xor_table_mask_generator_unit.sv */
// Result: a fetch's mask byte reaches the result ports, with done high, after the entry
//   register, the chain of level stages and the output register.
// Throughput: one item (write or fetch) per cycle while busy is low; each recursion
//   level is a stage with its own replica of the three tables, read in parallel.
// Reset: synchronous rst clears the pipeline valid bits and holds busy high until the
//   first edge after release. Tables are not cleared. The receiver cannot stall done.
`default_nettype none

module xor_table_mask_generator_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              opcode,
  input  wire logic [xtm_pkg::SEL_W-1:0]         table_select,
  input  wire logic [xtm_pkg::IDX_W-1:0]         table_index,
  input  wire logic [xtm_pkg::BYTE_W-1:0]        table_byte,
  input  wire logic [xtm_pkg::POSITION_BITS-1:0] mask_position,
  input  wire logic                              last_of_request,
  output logic                                   done,
  output logic [xtm_pkg::BYTE_W-1:0]             mask_byte,
  output logic                                   last_out
);

  // The level chain runs from the highest byte of the position down to byte zero.
  // Each level k looks at p = position >> 8k and, when p is at least the table size,
  // mixes first, second and two base entries into the running byte; the first level
  // where p drops below the table size adds base[p] and every level of higher k adds nothing.
  // Remainders mod the table size are built nibble by nibble from the top, two per level.

  xtm_pkg::item_t  entry;
  xtm_pkg::item_t  entry_next;
  xtm_pkg::item_t  chain_item [xtm_pkg::NUM_LEVELS+1];
  xtm_pkg::rdata_t chain_rd   [xtm_pkg::NUM_LEVELS+1];

  logic [xtm_pkg::NUM_LEVELS-1:0] act_v;
  logic [xtm_pkg::NUM_LEVELS-1:0] term_v;
  logic [xtm_pkg::BYTE_W-1:0]     mask_next;
  logic                           done_next;

  // Decide up front, for every level, whether it recurses or ends the recursion.
  always_comb begin
    for (int k = 0; k < xtm_pkg::NUM_LEVELS; k++) begin
      act_v[k] = (mask_position >> (8 * k)) >=
                 xtm_pkg::POSITION_BITS'(xtm_pkg::TABLE_SIZE);
    end
    term_v[0] = ~act_v[0];
    for (int k = 1; k < xtm_pkg::NUM_LEVELS; k++) begin
      term_v[k] = ~act_v[k] & act_v[k-1];
    end
  end

  always_comb begin
    entry_next.valid = start & ~busy;
    entry_next.wr    = (opcode == xtm_pkg::OP_WRITE);
    entry_next.sel   = table_select;
    entry_next.idx   = table_index;
    entry_next.wbyte = table_byte;
    entry_next.win   = xtm_pkg::WIN_W'(mask_position);
    entry_next.act   = act_v;
    entry_next.term  = term_v;
    entry_next.last  = last_of_request;
    entry_next.acc   = '0;
    entry_next.rem   = '0;   // position above the top level is zero
  end

  // Capture the transfer; hold busy high through reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
      busy        <= 1'b1;
    end else begin
      entry <= entry_next;
      busy  <= 1'b0;
    end
  end

  assign chain_item[0] = entry;
  assign chain_rd[0]   = '0;

  // Writes travel down the chain with the fetches, so each replica sees them in order.
  for (genvar s = 0; s < xtm_pkg::NUM_LEVELS; s++) begin : g_level
    xtm_level u_level (
      .clk      (clk),
      .rst      (rst),
      .item_in  (chain_item[s]),
      .rd_in    (chain_rd[s]),
      .item_out (chain_item[s+1]),
      .rd_out   (chain_rd[s+1])
    );
  end

  // Fold in the lowest level's table reads and drive the result for one cycle.
  assign mask_next = chain_item[xtm_pkg::NUM_LEVELS].acc ^
                     xtm_pkg::level_mix(chain_rd[xtm_pkg::NUM_LEVELS]);
  assign done_next = chain_item[xtm_pkg::NUM_LEVELS].valid &
                     ~chain_item[xtm_pkg::NUM_LEVELS].wr;

  always_ff @(posedge clk) begin
    mask_byte <= mask_next;
    last_out  <= chain_item[xtm_pkg::NUM_LEVELS].last;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= done_next;
    end
  end

endmodule

`default_nettype wire

/* design/xtm_checker.sv */
`default_nettype none

module xtm_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              start,
  input wire logic                              busy,
  input wire logic                              opcode,
  input wire logic                              last_of_request,
  input wire logic                              done,
  input wire logic                              last_out
);

  localparam int LAT = xtm_pkg::LATENCY;

  logic fetch_xfer;
  logic write_xfer;

  assign fetch_xfer = start && !busy && (opcode == xtm_pkg::OP_FETCH);
  assign write_xfer = start && !busy && (opcode == xtm_pkg::OP_WRITE);

  // Release from reset frees the command port on the next edge.
  a_busy_release: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> !busy)
    else $error("busy still high after reset release");

  // Every fetch gives its result a fixed number of cycles later, with its marker.
  a_fetch_result: assert property (@(posedge clk) disable iff (rst)
    fetch_xfer |-> ##LAT (done && last_out == $past(last_of_request, LAT)))
    else $error("fetch result missing or marker wrong");

  // A write gives no result.
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    write_xfer |-> ##LAT !done)
    else $error("result appeared for a table write");

  // No result without a matching fetch.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(fetch_xfer, LAT))
    else $error("result without a fetch");

endmodule

bind xor_table_mask_generator_unit xtm_checker u_xtm_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .opcode          (opcode),
  .last_of_request (last_of_request),
  .done            (done),
  .last_out        (last_out)
);

`default_nettype wire

/* sim/xtm_mask_checker.sv */
`timescale 1ns / 100ps

module xtm_mask_checker (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic                              busy,
  input  wire logic                              opcode,
  input  wire logic [xtm_pkg::SEL_W-1:0]         table_select,
  input  wire logic [xtm_pkg::IDX_W-1:0]         table_index,
  input  wire logic [xtm_pkg::BYTE_W-1:0]        table_byte,
  input  wire logic [xtm_pkg::POSITION_BITS-1:0] mask_position,
  input  wire logic                              last_of_request,
  input  wire logic                              done,
  input  wire logic [xtm_pkg::BYTE_W-1:0]        mask_byte,
  input  wire logic                              last_out,
  output int                                     errors,
  output int                                     outstanding
);

  typedef struct packed {
    logic [xtm_pkg::BYTE_W-1:0] mask;
    logic                       lst;
  } mask_result_t;

  logic [xtm_pkg::BYTE_W-1:0] first_tbl  [xtm_pkg::TABLE_SIZE];
  logic [xtm_pkg::BYTE_W-1:0] second_tbl [xtm_pkg::TABLE_SIZE];
  logic [xtm_pkg::BYTE_W-1:0] base_tbl   [xtm_pkg::TABLE_SIZE];

  mask_result_t expected_masks[$];

  initial begin
    errors      = 0;
    outstanding = 0;
    foreach (first_tbl[i]) begin
      first_tbl[i]  = '0;
      second_tbl[i] = '0;
      base_tbl[i]   = '0;
    end
  end

  // Walk the recursion down one position byte per level.
  function automatic logic [xtm_pkg::BYTE_W-1:0] predict_mask(
      logic [xtm_pkg::POSITION_BITS-1:0] pos);
    logic [xtm_pkg::POSITION_BITS-1:0] p;
    logic [xtm_pkg::POSITION_BITS-1:0] hi;
    logic [xtm_pkg::BYTE_W-1:0]        acc;
    logic [xtm_pkg::ADDR_W-1:0]        i_first;
    logic [xtm_pkg::ADDR_W-1:0]        i_hi;
    logic [xtm_pkg::ADDR_W-1:0]        i_low;
    p   = pos;
    acc = '0;
    while (p >= xtm_pkg::POSITION_BITS'(xtm_pkg::TABLE_SIZE)) begin
      hi      = p >> 8;
      i_first = xtm_pkg::ADDR_W'((p >> 4) % xtm_pkg::TABLE_SIZE);
      i_hi    = xtm_pkg::ADDR_W'(hi % xtm_pkg::TABLE_SIZE);
      i_low   = xtm_pkg::ADDR_W'(p % xtm_pkg::TABLE_SIZE);
      acc     = acc ^ first_tbl[i_first] ^ second_tbl[i_hi]
                    ^ base_tbl[i_low] ^ base_tbl[i_hi];
      p       = hi;
    end
    return acc ^ base_tbl[xtm_pkg::ADDR_W'(p)];
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    $display("[%0t] mask check: %s", $time, what);
  endtask

  always @(posedge clk) begin
    mask_result_t want;
    if (!rst) begin
      // Compare the result first, so that a fetch taken at the same edge queues behind it.
      if (done) begin
        if (expected_masks.size() == 0) begin
          report_mismatch($sformatf("unexpected mask byte %0h last %0b", mask_byte, last_out));
        end else begin
          want = expected_masks.pop_front();
          if (mask_byte !== want.mask) begin
            report_mismatch($sformatf("mask_byte %0h, want %0h", mask_byte, want.mask));
          end
          if (last_out !== want.lst) begin
            report_mismatch($sformatf("last_out %0b, want %0b", last_out, want.lst));
          end
        end
      end
      if (start && !busy) begin
        if (opcode == xtm_pkg::OP_WRITE) begin
          if (table_index < xtm_pkg::TABLE_SIZE) begin
            case (table_select)
              xtm_pkg::SEL_FIRST: begin
                first_tbl[table_index] = table_byte;
              end
              xtm_pkg::SEL_SECOND: begin
                second_tbl[table_index] = table_byte;
              end
              xtm_pkg::SEL_BASE: begin
                base_tbl[table_index] = table_byte;
              end
              default: begin
              end
            endcase
          end
        end else begin
          want.mask = predict_mask(mask_position);
          want.lst  = last_of_request;
          expected_masks.push_back(want);
        end
      end
    end
    outstanding <= expected_masks.size();
  end

endmodule

/* sim/xor_table_mask_generator_unit_tb.sv */
`timescale 1ns / 100ps

module xor_table_mask_generator_unit_tb;

  // Select code that names no table; writes with it must leave every table alone.
  localparam logic [xtm_pkg::SEL_W-1:0] SEL_UNUSED = 2'd3;
  localparam logic [xtm_pkg::POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [xtm_pkg::POSITION_BITS-1:0] POS_TBL_END =
    xtm_pkg::POSITION_BITS'(xtm_pkg::TABLE_SIZE);
  localparam logic [xtm_pkg::POSITION_BITS-1:0] POS_TBL_LAST =
    xtm_pkg::POSITION_BITS'(xtm_pkg::TABLE_SIZE - 1);
  localparam logic [xtm_pkg::IDX_W-1:0] IDX_END  = xtm_pkg::IDX_W'(xtm_pkg::TABLE_SIZE);
  localparam logic [xtm_pkg::IDX_W-1:0] IDX_LAST = xtm_pkg::IDX_W'(xtm_pkg::TABLE_SIZE - 1);
  // Items after the table load, so that the whole run stays near 1700 items.
  localparam int RANDOM_ITEMS = 860;

  logic                              clk;
  logic                              rst;
  logic                              start;
  logic                              busy;
  logic                              opcode;
  logic [xtm_pkg::SEL_W-1:0]         table_select;
  logic [xtm_pkg::IDX_W-1:0]         table_index;
  logic [xtm_pkg::BYTE_W-1:0]        table_byte;
  logic [xtm_pkg::POSITION_BITS-1:0] mask_position;
  logic                              last_of_request;
  logic                              done;
  logic [xtm_pkg::BYTE_W-1:0]        mask_byte;
  logic                              last_out;

  int failures;
  int outstanding;
  bit idle_on;

  xor_table_mask_generator_unit dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .opcode          (opcode),
    .table_select    (table_select),
    .table_index     (table_index),
    .table_byte      (table_byte),
    .mask_position   (mask_position),
    .last_of_request (last_of_request),
    .done            (done),
    .mask_byte       (mask_byte),
    .last_out        (last_out)
  );

  // The checker sees every transfer on both sides, mirrors the tables and
  // scores each mask byte; the top only feeds items and gives the verdict.
  xtm_mask_checker mask_checker (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .opcode          (opcode),
    .table_select    (table_select),
    .table_index     (table_index),
    .table_byte      (table_byte),
    .mask_position   (mask_position),
    .last_of_request (last_of_request),
    .done            (done),
    .mask_byte       (mask_byte),
    .last_out        (last_out),
    .errors          (failures),
    .outstanding     (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run: far beyond a few thousand items at worst-case gaps.
  initial begin
    #2ms;
    $display("[xor_table_mask_generator_unit] ERROR");
    $finish;
  end

  // Draw a position of random bit length, so that short positions (a single
  // table lookup) and deep recursions both turn up often.
  function automatic logic [xtm_pkg::POSITION_BITS-1:0] rand_position();
    logic [63:0] raw;
    int          w;
    raw = {$urandom, $urandom};
    w   = $urandom_range(0, xtm_pkg::POSITION_BITS);
    raw = raw & ((64'd1 << w) - 64'd1);
    return raw[xtm_pkg::POSITION_BITS-1:0];
  endfunction

  function automatic logic [xtm_pkg::BYTE_W-1:0] rand_byte();
    return xtm_pkg::BYTE_W'($urandom);
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom);
  endfunction

  function automatic logic [xtm_pkg::SEL_W-1:0] rand_sel();
    return xtm_pkg::SEL_W'($urandom);
  endfunction

  function automatic logic [xtm_pkg::IDX_W-1:0] rand_idx();
    return xtm_pkg::IDX_W'($urandom);
  endfunction

  // Present one item from a falling edge and hold it until the transfer.
  // Leave start high when the next item follows with no gap.
  task automatic transfer_item(input logic op, input logic [xtm_pkg::SEL_W-1:0] sel,
                               input logic [xtm_pkg::IDX_W-1:0] idx,
                               input logic [xtm_pkg::BYTE_W-1:0] val,
                               input logic [xtm_pkg::POSITION_BITS-1:0] pos,
                               input logic lst);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start           <= 1'b1;
    opcode          <= op;
    table_select    <= sel;
    table_index     <= idx;
    table_byte      <= val;
    mask_position   <= pos;
    last_of_request <= lst;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Hold off the sender until every mask byte in flight has come back.
  task automatic wait_for_results();
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  initial begin
    int                                counted;
    int                                kind;
    int                                len;
    logic [xtm_pkg::SEL_W-1:0]         sel;
    logic [xtm_pkg::IDX_W-1:0]         idx;
    logic [xtm_pkg::POSITION_BITS-1:0] pos;

    rst             = 1'b1;
    start           = 1'b0;
    opcode          = xtm_pkg::OP_WRITE;
    table_select    = xtm_pkg::SEL_FIRST;
    table_index     = '0;
    table_byte      = '0;
    mask_position   = '0;
    last_of_request = 1'b0;
    idle_on         = 1'b1;
    counted         = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Load every entry of all three tables, so that no fetch ever reads an
    // entry that was never written.
    for (int i = 0; i < xtm_pkg::TABLE_SIZE; i++) begin
      idx = xtm_pkg::IDX_W'(i);
      transfer_item(xtm_pkg::OP_WRITE, xtm_pkg::SEL_FIRST, idx, rand_byte(),
                    rand_position(), rand_bit());
      transfer_item(xtm_pkg::OP_WRITE, xtm_pkg::SEL_SECOND, idx, rand_byte(),
                    rand_position(), rand_bit());
      transfer_item(xtm_pkg::OP_WRITE, xtm_pkg::SEL_BASE, idx, rand_byte(),
                    rand_position(), rand_bit());
    end

    // Directed items: extreme bytes and indexes, ignored writes, and positions
    // on either side of the table boundary and of the 256 and 0x1000 edges.
    transfer_item(xtm_pkg::OP_WRITE, xtm_pkg::SEL_BASE, '0, 8'hFF, '0, 1'b0);
    transfer_item(xtm_pkg::OP_WRITE, xtm_pkg::SEL_FIRST, IDX_LAST, 8'h00, POS_MAX, 1'b1);
    transfer_item(xtm_pkg::OP_WRITE, xtm_pkg::SEL_SECOND, IDX_LAST, 8'hFF, '0, 1'b0);
    transfer_item(xtm_pkg::OP_WRITE, xtm_pkg::SEL_BASE, IDX_LAST, 8'h5A, POS_MAX, 1'b1);
    transfer_item(xtm_pkg::OP_WRITE, SEL_UNUSED, '0, 8'hFF, '0, 1'b0);
    transfer_item(xtm_pkg::OP_WRITE, xtm_pkg::SEL_FIRST, IDX_END, 8'hFF, '0, 1'b0);
    transfer_item(xtm_pkg::OP_WRITE, xtm_pkg::SEL_BASE, 9'h1FF, 8'hA5, POS_MAX, 1'b1);
    transfer_item(xtm_pkg::OP_FETCH, SEL_UNUSED, 9'h1FF, 8'hFF, '0, 1'b0);
    transfer_item(xtm_pkg::OP_FETCH, xtm_pkg::SEL_FIRST, '0, 8'h00, POS_TBL_LAST, 1'b0);
    transfer_item(xtm_pkg::OP_FETCH, xtm_pkg::SEL_FIRST, '0, 8'h00, POS_TBL_END, 1'b1);
    transfer_item(xtm_pkg::OP_FETCH, xtm_pkg::SEL_FIRST, '0, 8'h00, 40'd255, 1'b0);
    transfer_item(xtm_pkg::OP_FETCH, xtm_pkg::SEL_FIRST, '0, 8'h00, 40'd256, 1'b0);
    transfer_item(xtm_pkg::OP_FETCH, xtm_pkg::SEL_FIRST, '0, 8'h00, 40'hFFF, 1'b0);
    transfer_item(xtm_pkg::OP_FETCH, xtm_pkg::SEL_FIRST, '0, 8'h00, 40'h1000, 1'b1);
    transfer_item(xtm_pkg::OP_FETCH, xtm_pkg::SEL_FIRST, '0, 8'h00, 40'hFFFF, 1'b0);
    transfer_item(xtm_pkg::OP_FETCH, xtm_pkg::SEL_FIRST, '0, 8'h00, 40'h8000000000, 1'b0);
    transfer_item(xtm_pkg::OP_FETCH, xtm_pkg::SEL_FIRST, '0, 8'h00, POS_MAX - POS_TBL_END,
                  1'b0);
    transfer_item(xtm_pkg::OP_FETCH, xtm_pkg::SEL_FIRST, '0, 8'h00, POS_MAX, 1'b1);
    // A write straight after a fetch must not disturb the mask in flight.
    transfer_item(xtm_pkg::OP_WRITE, xtm_pkg::SEL_BASE, '0, 8'h00, POS_MAX, 1'b0);
    transfer_item(xtm_pkg::OP_FETCH, xtm_pkg::SEL_BASE, '0, 8'h00, 40'd0, 1'b1);
    wait_for_results();

    // Random part: mostly runs of consecutive positions closed by the last
    // mark, as a decryption pass fetches them, with table rewrites and lone
    // fetches mixed in. Switch idling off for some bursts.
    while (counted < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      kind    = $urandom_range(0, 9);
      if (kind <= 6) begin
        len = $urandom_range(1, 16);
        pos = rand_position();
        for (int k = 0; k < len; k++) begin
          transfer_item(xtm_pkg::OP_FETCH, rand_sel(), rand_idx(), rand_byte(),
                        pos + xtm_pkg::POSITION_BITS'(k), k == len - 1);
        end
        counted += len;
      end else if (kind <= 8) begin
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
          sel = xtm_pkg::SEL_W'($urandom_range(0, 3));
          idx = ($urandom_range(0, 5) == 0) ?
                xtm_pkg::IDX_W'($urandom_range(0, 511)) :
                xtm_pkg::IDX_W'($urandom_range(0, xtm_pkg::TABLE_SIZE - 1));
          transfer_item(xtm_pkg::OP_WRITE, sel, idx, rand_byte(), rand_position(),
                        rand_bit());
          counted++;
        end
      end else begin
        transfer_item(xtm_pkg::OP_FETCH, rand_sel(), rand_idx(), rand_byte(),
                      rand_position(), rand_bit());
        counted++;
      end
      if ($urandom_range(0, 199) == 0) begin
        wait_for_results();
      end
    end

    // Drain, then give the pipeline time to show any stray result.
    wait_for_results();
    repeat (xtm_pkg::LATENCY + 4) @(negedge clk);
    if (failures == 0) begin
      $display("[xor_table_mask_generator_unit] OK");
    end else begin
      $display("[xor_table_mask_generator_unit] ERROR");
    end
    $finish;
  end

endmodule
